// File: hw/rtl/gcpa_pkg.sv
package gcpa_pkg;

   localparam int COLUMNS       = 4;
   localparam int SAMPLE_BITS   = 16;
   localparam int ACC_BITS      = 48;
   localparam int PROD_BITS     = 2 * SAMPLE_BITS;
   localparam int COUNT_BITS    = 20;
   localparam int TRI_SIZE      = (COLUMNS * (COLUMNS + 1)) / 2;
   localparam int PROD_COUNT    = 1 + COLUMNS + TRI_SIZE;
   localparam int STAT_COUNT    = 3 + 2 * COLUMNS + TRI_SIZE;
   localparam int STAT_IDX_BITS = 5;
   localparam int CLUSTER_BITS  = 4;
   localparam int MODE_BITS     = 2;
   localparam int CFG_BITS      = 3;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [STAT_IDX_BITS-1:0] LAST_STAT = STAT_IDX_BITS'(STAT_COUNT - 1);

   localparam logic [MODE_BITS-1:0] MODE_ACC   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

   // register index within the csr map (byte address bit 2)
   localparam logic CSR_IDX_COLS = 1'b0;
   localparam logic [CFG_BITS-1:0] COLS_RESET = 3'd4;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_ACC,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef sample_type [COLUMNS-1:0]      sample_vec_type;
   typedef prod_type [PROD_COUNT-1:0]     prod_vec_type;
   typedef acc_type [STAT_COUNT-1:0]      row_type;

endpackage

// File: hw/rtl/grouped_cross_product_accumulator_core.sv
// Per-cluster regression statistics. Accumulate and clear items are taken one per
// cycle, with back-to-back rows on the same cluster forwarded inside the block; a
// read item delivers its cluster's 21 statistics as 21 beats, one per cycle while
// rsp_stall is low, from a single output buffer, so an item behind a read waits
// until the previous run's last beat is taken. The first beat is presented once the
// read has passed the input stage and the update stage into the output buffer. The
// statistic store is one row-wide RAM of min(CLUSTERS, 16) rows with a valid flop
// per row, so reset clears it at once with no clearing pass; products are Q15.16,
// sample sums Q39.8, counts and sums saturate.
module grouped_cross_product_accumulator_core #(
   parameter int CLUSTERS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [gcpa_pkg::MODE_BITS-1:0]            req_mode,
   input  logic [gcpa_pkg::CLUSTER_BITS-1:0]         req_cluster,
   input  logic signed [gcpa_pkg::SAMPLE_BITS-1:0]   req_y_sample,
   input  logic signed [gcpa_pkg::SAMPLE_BITS-1:0]   req_x0,
   input  logic signed [gcpa_pkg::SAMPLE_BITS-1:0]   req_x1,
   input  logic signed [gcpa_pkg::SAMPLE_BITS-1:0]   req_x2,
   input  logic signed [gcpa_pkg::SAMPLE_BITS-1:0]   req_x3,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic [gcpa_pkg::CLUSTER_BITS-1:0]         rsp_out_cluster,
   output logic [gcpa_pkg::STAT_IDX_BITS-1:0]        rsp_stat_index,
   output logic signed [gcpa_pkg::ACC_BITS-1:0]      rsp_stat_value,
   output logic                                      rsp_last,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [gcpa_pkg::CSR_ADDR_BITS-1:0]        csr_paddr,
   input  logic [gcpa_pkg::CSR_DATA_BITS-1:0]        csr_pwdata,
   output logic [gcpa_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                      csr_pready
);

   localparam int MAX_ROWS = 1 << gcpa_pkg::CLUSTER_BITS;
   localparam int ROWS     = (CLUSTERS < MAX_ROWS) ? CLUSTERS : MAX_ROWS;
   localparam int AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RW       = gcpa_pkg::STAT_COUNT * gcpa_pkg::ACC_BITS;

   // csr
   logic [gcpa_pkg::CFG_BITS-1:0] cols_ff;
   logic                          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= gcpa_pkg::COLS_RESET;
      end else if (csr_wr && csr_paddr[2] == gcpa_pkg::CSR_IDX_COLS) begin
         cols_ff <= csr_pwdata[gcpa_pkg::CFG_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == gcpa_pkg::CSR_IDX_COLS) begin
         csr_prdata = {{(gcpa_pkg::CSR_DATA_BITS-gcpa_pkg::CFG_BITS){1'b0}}, cols_ff};
      end
   end

   // input stage
   gcpa_pkg::sample_vec_type          req_x;
   gcpa_pkg::sample_vec_type          x_in;
   gcpa_pkg::op_type                  op_in;
   logic                              s1_valid_ff;
   gcpa_pkg::op_type                  s1_op_ff;
   logic [gcpa_pkg::CLUSTER_BITS-1:0] s1_cluster_ff;
   logic [AW-1:0]                     s1_addr_ff;
   gcpa_pkg::sample_type              s1_y_ff;
   gcpa_pkg::sample_vec_type          s1_x_ff;
   gcpa_pkg::prod_vec_type            prod_in;

   // update stage
   logic                              s2_valid_ff;
   gcpa_pkg::op_type                  s2_op_ff;
   logic [gcpa_pkg::CLUSTER_BITS-1:0] s2_cluster_ff;
   logic [AW-1:0]                     s2_addr_ff;
   gcpa_pkg::sample_type              s2_y_ff;
   gcpa_pkg::sample_vec_type          s2_x_ff;
   gcpa_pkg::prod_vec_type            s2_prod_ff;
   logic                              s2_stall;
   logic                              s2_read_go;
   logic                              ram_we;
   logic [RW-1:0]                     ram_rdata;
   gcpa_pkg::row_type                 row_old;
   gcpa_pkg::row_type                 row_new;
   logic [ROWS-1:0]                   row_valid_ff;
   logic                              wb_valid_ff;
   logic [AW-1:0]                     wb_addr_ff;
   gcpa_pkg::row_type                 wb_row_ff;

   // output buffer
   logic                                obuf_valid_ff;
   gcpa_pkg::row_type                   obuf_row_ff;
   logic [gcpa_pkg::CLUSTER_BITS-1:0]   obuf_cluster_ff;
   logic [gcpa_pkg::STAT_IDX_BITS-1:0]  obuf_idx_ff;
   logic                                obuf_take;
   logic                                obuf_free;

   assign req_x = {req_x3, req_x2, req_x1, req_x0};

   always_comb begin
      for (int c = 0; c < gcpa_pkg::COLUMNS; c++) begin
         x_in[c] = (gcpa_pkg::CFG_BITS'(c) < cols_ff) ? req_x[c] : '0;
      end
      op_in = gcpa_pkg::OP_NONE;
      if (32'(req_cluster) < CLUSTERS) begin
         case (req_mode)
            gcpa_pkg::MODE_ACC:   op_in = gcpa_pkg::OP_ACC;
            gcpa_pkg::MODE_READ:  op_in = gcpa_pkg::OP_READ;
            gcpa_pkg::MODE_CLEAR: op_in = gcpa_pkg::OP_CLEAR;
            default:              op_in = gcpa_pkg::OP_NONE;
         endcase
      end
   end

   assign req_stall = s1_valid_ff && s2_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         s1_op_ff      <= op_in;
         s1_cluster_ff <= req_cluster;
         s1_addr_ff    <= req_cluster[AW-1:0];
         s1_y_ff       <= req_y_sample;
         s1_x_ff       <= x_in;
      end
   end

   // y*y, x*y, then the upper triangle of x*x, row-major
   always_comb begin
      int t;
      t = 1 + gcpa_pkg::COLUMNS;
      prod_in[0] = s1_y_ff * s1_y_ff;
      for (int c = 0; c < gcpa_pkg::COLUMNS; c++) begin
         prod_in[1+c] = s1_x_ff[c] * s1_y_ff;
      end
      for (int c = 0; c < gcpa_pkg::COLUMNS; c++) begin
         for (int c2 = c; c2 < gcpa_pkg::COLUMNS; c2++) begin
            prod_in[t] = s1_x_ff[c] * s1_x_ff[c2];
            t++;
         end
      end
   end

   assign obuf_take  = obuf_valid_ff && !rsp_stall;
   assign obuf_free  = !obuf_valid_ff || (obuf_take && obuf_idx_ff == gcpa_pkg::LAST_STAT);
   assign s2_stall   = s2_valid_ff && s2_op_ff == gcpa_pkg::OP_READ && !obuf_free;
   assign s2_read_go = s2_valid_ff && s2_op_ff == gcpa_pkg::OP_READ && obuf_free;
   assign ram_we     = s2_valid_ff &&
                       (s2_op_ff == gcpa_pkg::OP_ACC || s2_op_ff == gcpa_pkg::OP_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (!s2_stall) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (!s2_stall) begin
         s2_op_ff      <= s1_op_ff;
         s2_cluster_ff <= s1_cluster_ff;
         s2_addr_ff    <= s1_addr_ff;
         s2_y_ff       <= s1_y_ff;
         s2_x_ff       <= s1_x_ff;
         s2_prod_ff    <= prod_in;
      end
   end

   gcpa_ram #(
      .WIDTH (RW),
      .DEPTH (ROWS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s2_addr_ff),
      .wr_data (row_new),
      .rd_en   (!s2_stall),
      .rd_addr (s1_addr_ff),
      .rd_data (ram_rdata)
   );

   // the row written in the same cycle as this item's read is not in ram_rdata
   always_comb begin
      if (wb_valid_ff && wb_addr_ff == s2_addr_ff) begin
         row_old = wb_row_ff;
      end else if (row_valid_ff[s2_addr_ff]) begin
         row_old = ram_rdata;
      end else begin
         row_old = '0;
      end
   end

   gcpa_row_update u_update (
      .op      (s2_op_ff),
      .row_old (row_old),
      .y       (s2_y_ff),
      .x       (s2_x_ff),
      .prod    (s2_prod_ff),
      .row_new (row_new)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         wb_valid_ff  <= 1'b0;
      end else begin
         if (ram_we) begin
            row_valid_ff[s2_addr_ff] <= 1'b1;
         end
         if (!s2_stall) begin
            wb_valid_ff <= ram_we;
         end
      end
      if (!s2_stall) begin
         wb_addr_ff <= s2_addr_ff;
         wb_row_ff  <= row_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_valid_ff <= 1'b0;
      end else if (s2_read_go) begin
         obuf_valid_ff <= 1'b1;
      end else if (obuf_take && obuf_idx_ff == gcpa_pkg::LAST_STAT) begin
         obuf_valid_ff <= 1'b0;
      end
      if (s2_read_go) begin
         obuf_row_ff     <= row_old;
         obuf_cluster_ff <= s2_cluster_ff;
         obuf_idx_ff     <= '0;
      end else if (obuf_take) begin
         obuf_row_ff <= obuf_row_ff >> gcpa_pkg::ACC_BITS;
         obuf_idx_ff <= gcpa_pkg::STAT_IDX_BITS'(obuf_idx_ff + 1'b1);
      end
   end

   assign rsp_valid       = obuf_valid_ff;
   assign rsp_out_cluster = obuf_cluster_ff;
   assign rsp_stat_index  = obuf_idx_ff;
   assign rsp_stat_value  = obuf_row_ff[0];
   assign rsp_last        = obuf_idx_ff == gcpa_pkg::LAST_STAT;

`ifndef SYNTHESIS
   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> row_valid_ff[$past(s2_addr_ff)])
      else $error("written row not marked valid");

   // the forwarding register holds its value while a read waits in the update stage
   a_forward_follows_write: assert property (@(posedge clock) disable iff (reset)
      (wb_valid_ff && !$past(s2_stall)) |-> $past(ram_we))
      else $error("forwarding register valid without a write");

   a_run_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_stat_index == '0)
      else $error("statistics run does not start at index zero");

   a_run_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=>
         rsp_valid && rsp_stat_index ==
            gcpa_pkg::STAT_IDX_BITS'($past(rsp_stat_index) + 1'b1))
      else $error("statistics run skipped or broke off");
`endif

endmodule

// File: hw/rtl/gcpa_ram.sv
module gcpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gcpa_row_update.sv
module gcpa_row_update (
   input  gcpa_pkg::op_type         op,
   input  gcpa_pkg::row_type        row_old,
   input  gcpa_pkg::sample_type     y,
   input  gcpa_pkg::sample_vec_type x,
   input  gcpa_pkg::prod_vec_type   prod,
   output gcpa_pkg::row_type        row_new
);

   localparam int AB = gcpa_pkg::ACC_BITS;
   localparam int SB = gcpa_pkg::SAMPLE_BITS;
   localparam int PB = gcpa_pkg::PROD_BITS;
   localparam int CB = gcpa_pkg::COUNT_BITS;

   function automatic gcpa_pkg::acc_type sat_add(input gcpa_pkg::acc_type a,
                                                 input gcpa_pkg::acc_type b);
      logic [AB:0] sum;
      sum = {a[AB-1], a} + {b[AB-1], b};
      if (sum[AB] != sum[AB-1]) begin
         return sum[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
      end
      return sum[AB-1:0];
   endfunction

   function automatic gcpa_pkg::acc_type ext_sample(input gcpa_pkg::sample_type s);
      return {{(AB-SB){s[SB-1]}}, s};
   endfunction

   function automatic gcpa_pkg::acc_type ext_prod(input gcpa_pkg::prod_type p);
      return {{(AB-PB){p[PB-1]}}, p};
   endfunction

   logic [CB-1:0] count;
   logic [CB-1:0] count_next;

   assign count      = row_old[0][CB-1:0];
   assign count_next = (&count) ? count : CB'(count + 1'b1);

   always_comb begin
      row_new = '0;
      case (op)
         gcpa_pkg::OP_ACC: begin
            row_new[0] = {{(AB-CB){1'b0}}, count_next};
            row_new[1] = sat_add(row_old[1], ext_sample(y));
            row_new[2] = sat_add(row_old[2], ext_prod(prod[0]));
            for (int c = 0; c < gcpa_pkg::COLUMNS; c++) begin
               row_new[3+c] = sat_add(row_old[3+c], ext_sample(x[c]));
            end
            // x*y then the upper triangle follow the column sums
            for (int p = 1; p < gcpa_pkg::PROD_COUNT; p++) begin
               row_new[2+gcpa_pkg::COLUMNS+p] =
                  sat_add(row_old[2+gcpa_pkg::COLUMNS+p], ext_prod(prod[p]));
            end
         end
         gcpa_pkg::OP_CLEAR: row_new = '0;
         default: row_new = row_old;
      endcase
   end

endmodule
